FILE: rtl/polygon_fence_point_test_assert.svh
// Assertion macros for the polygon fence point test block.
`ifndef POLYGON_FENCE_POINT_TEST_ASSERT_SVH
`define POLYGON_FENCE_POINT_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PFPT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfpt assertion failed");
// Next-cycle implication.
`define PFPT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfpt assertion failed");
`else
`define PFPT_ASSERT_IMP(name, clk, rst, ante, cons)
`define PFPT_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pfpt_pkg.sv
// Shared constants, types and request codes for the polygon fence point test.
package pfpt_pkg;

  localparam int MAX_FENCES   = 8;
  localparam int MAX_VERTICES = 32;
  localparam int COORD_W      = 32;

  localparam int FENCE_W  = $clog2(MAX_FENCES);
  localparam int VERT_W   = $clog2(MAX_VERTICES);
  localparam int ADDR_W   = FENCE_W + VERT_W;
  localparam int RAM_DEPTH = MAX_FENCES * MAX_VERTICES;
  localparam int COUNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int LIMIT_W  = $clog2(MAX_FENCES + 1);
  localparam int CFG_W    = 4;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;

  // fences with this many vertices or fewer never hold a point
  localparam int SMALL_FENCE = 2;

  localparam logic [1:0] REQ_WRITE_VERTEX = 2'd0;
  localparam logic [1:0] REQ_SET_COUNT    = 2'd1;
  localparam logic [1:0] REQ_QUERY        = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one vertex read travelling down the edge pipeline
  typedef struct packed {
    logic               valid;
    logic               prime;
    logic               last;
    logic [FENCE_W-1:0] fence;
  } edge_tag_t;

  // edge pipeline status back to the sequencer
  typedef struct packed {
    logic               busy;
    logic               found;
    logic [FENCE_W-1:0] index;
  } edge_stat_t;

endpackage

FILE: rtl/polygon_fence_point_test.sv
// Top level of the polygon fence point test: request decode, fence sequencer, result register.
//
// Requests come in on in_valid/in_stall with req_type selecting a vertex write,
// a fence vertex count set, or a point query. Results leave on out_valid/out_stall,
// one per query and none for other requests. fences_in_use is written through
// cfg_we/cfg_wdata; the user writes it only while idle, which the block does not enforce.
// Vertex writes and count sets are applied as they are accepted. A query walks fences 0 up to
// min(fences_in_use, 8)-1; a fence with n > 2 vertices is walked with one read of
// its last vertex, then one edge per cycle from the vertex RAM read port; a
// smaller fence is skipped without reads. After the walk the three-stage edge pipeline
// drains and the result is registered. in_stall is high for the whole query.
// Reset clears all vertex counts to zero and sets fences_in_use to 8; vertex
// coordinates hold no reset value and must be written before a fence uses them.
// A result waiting under out_stall does not block vertex writes or count sets;
// a following query runs and then holds until the result register frees.
module polygon_fence_point_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pfpt_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [pfpt_pkg::FENCE_W-1:0]        fence_sel,
  input  logic [pfpt_pkg::VERT_W-1:0]         vertex_sel,
  input  logic signed [pfpt_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pfpt_pkg::COORD_W-1:0] coord_z,
  input  logic [pfpt_pkg::COUNT_W-1:0]        vertex_total,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                inside_res,
  output logic [pfpt_pkg::FENCE_W-1:0]        fence_index
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                     state;
  logic [pfpt_pkg::CFG_W-1:0]     fences_in_use;
  logic [pfpt_pkg::COUNT_W-1:0]   vcount [pfpt_pkg::MAX_FENCES];
  logic [pfpt_pkg::LIMIT_W-1:0]   limit;
  logic [pfpt_pkg::LIMIT_W-1:0]   fence_cnt;
  logic [pfpt_pkg::COUNT_W-1:0]   step;
  pfpt_pkg::coord_t               px, pz;

  logic                           in_accept, out_free, clear;
  logic                           ram_we;
  logic [pfpt_pkg::ADDR_W-1:0]    waddr, raddr;
  logic [pfpt_pkg::COUNT_W-1:0]   cur_n, vidx;
  pfpt_pkg::coord_t               rd_x, rd_z;
  pfpt_pkg::edge_tag_t            tag;
  pfpt_pkg::edge_stat_t           stat;
  logic                           walk_done, small_fence;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign clear     = in_accept && (req_type == pfpt_pkg::REQ_QUERY);

  // vertex write decode
  assign ram_we = in_accept && (req_type == pfpt_pkg::REQ_WRITE_VERTEX) &&
                  (int'(fence_sel) < pfpt_pkg::MAX_FENCES) &&
                  (int'(vertex_sel) < pfpt_pkg::MAX_VERTICES);
  assign waddr  = {fence_sel, vertex_sel};

  pfpt_ram #(.WIDTH(pfpt_pkg::COORD_W), .DEPTH(pfpt_pkg::RAM_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (coord_x),
    .raddr (raddr),
    .rdata (rd_x)
  );

  pfpt_ram #(.WIDTH(pfpt_pkg::COORD_W), .DEPTH(pfpt_pkg::RAM_DEPTH)) u_ram_z (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (coord_z),
    .raddr (raddr),
    .rdata (rd_z)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fences_in_use <= pfpt_pkg::CFG_W'(pfpt_pkg::MAX_FENCES);
    end else if (cfg_we) begin
      fences_in_use <= cfg_wdata;
    end
  end

  // vertex counts, saturated at the fence capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pfpt_pkg::MAX_FENCES; k++) begin
        vcount[k] <= '0;
      end
    end else if (in_accept && (req_type == pfpt_pkg::REQ_SET_COUNT) &&
                 (int'(fence_sel) < pfpt_pkg::MAX_FENCES)) begin
      if (int'(vertex_total) > pfpt_pkg::MAX_VERTICES) begin
        vcount[fence_sel] <= pfpt_pkg::COUNT_W'(pfpt_pkg::MAX_VERTICES);
      end else begin
        vcount[fence_sel] <= vertex_total;
      end
    end
  end

  // edge read stream: last vertex first to prime j, then vertices 0..n-1
  always_comb begin
    cur_n       = vcount[fence_cnt[pfpt_pkg::FENCE_W-1:0]];
    walk_done   = (fence_cnt == limit);
    small_fence = (int'(cur_n) <= pfpt_pkg::SMALL_FENCE);
    vidx        = (step == '0) ? (cur_n - 1'b1) : (step - 1'b1);
    raddr       = {fence_cnt[pfpt_pkg::FENCE_W-1:0], vidx[pfpt_pkg::VERT_W-1:0]};
    tag.valid   = (state == ST_RUN) && !walk_done && !small_fence;
    tag.prime   = (step == '0);
    tag.last    = (step == cur_n);
    tag.fence   = fence_cnt[pfpt_pkg::FENCE_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (clear) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (walk_done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.busy && out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query point, fence walk counters
  always_ff @(posedge clk) begin
    if (clear) begin
      px        <= coord_x;
      pz        <= coord_z;
      fence_cnt <= '0;
      step      <= '0;
      if (int'(fences_in_use) > pfpt_pkg::MAX_FENCES) begin
        limit <= pfpt_pkg::LIMIT_W'(pfpt_pkg::MAX_FENCES);
      end else begin
        limit <= pfpt_pkg::LIMIT_W'(fences_in_use);
      end
    end else if (state == ST_RUN && !walk_done) begin
      if (small_fence || tag.last) begin
        fence_cnt <= fence_cnt + 1'b1;
        step      <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  pfpt_edge_unit u_edge (
    .clk    (clk),
    .rst    (rst),
    .clear  (clear),
    .tag_in (tag),
    .rd_x   (rd_x),
    .rd_z   (rd_z),
    .px     (px),
    .pz     (pz),
    .stat   (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DRAIN && !stat.busy && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN && !stat.busy && out_free) begin
      inside_res  <= stat.found;
      fence_index <= stat.index;
    end
  end

`include "polygon_fence_point_test_assert.svh"

  // no pipeline traffic while requests are taken
  `PFPT_ASSERT_IMP(a_idle_empty, clk, rst, state == ST_IDLE, !stat.busy)
  // reads are only issued during the fence walk
  `PFPT_ASSERT_IMP(a_issue_run, clk, rst, tag.valid, state == ST_RUN)
  // a query starts the walk on the next cycle
  `PFPT_ASSERT_NXT(a_query_start, clk, rst, clear, state == ST_RUN && !in_stall == 1'b0)
  // a miss reports fence zero
  `PFPT_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !inside_res, fence_index == '0)

endmodule

FILE: rtl/pfpt_ram.sv
// Generic single write port, single read port RAM with registered read.
module pfpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pfpt_edge_unit.sv
// Edge crossing pipeline: differences, cross products, compare and parity per fence.
module pfpt_edge_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  pfpt_pkg::edge_tag_t tag_in,
  input  pfpt_pkg::coord_t    rd_x,
  input  pfpt_pkg::coord_t    rd_z,
  input  pfpt_pkg::coord_t    px,
  input  pfpt_pkg::coord_t    pz,
  output pfpt_pkg::edge_stat_t stat
);

  pfpt_pkg::edge_tag_t tag1, tag2, tag3;
  pfpt_pkg::coord_t    prev_x, prev_z;

  logic signed [pfpt_pkg::DIFF_W-1:0] dz_p, dx_e, dx_p, dz_e;
  logic signed [pfpt_pkg::DIFF_W-1:0] dz_p2, dx_e2, dx_p2, dz_e2;
  logic signed [pfpt_pkg::PROD_W-1:0] lhs3, rhs3;
  logic spans, xnear, cand2, cand3, dpos3;
  logic parity, found, hit, flip, odd;
  logic [pfpt_pkg::FENCE_W-1:0] index;

  // tag registers: tag1 lines up with the registered RAM read, tag2 and tag3 with the stages behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  // stage 1: current vertex i from RAM, previous vertex j from register
  always_comb begin
    spans = ((rd_z < pz) && (prev_z >= pz)) || ((prev_z < pz) && (rd_z >= pz));
    xnear = (rd_x <= px) || (prev_x <= px);
    dz_p  = pfpt_pkg::DIFF_W'(pz)     - pfpt_pkg::DIFF_W'(rd_z);
    dx_e  = pfpt_pkg::DIFF_W'(prev_x) - pfpt_pkg::DIFF_W'(rd_x);
    dx_p  = pfpt_pkg::DIFF_W'(px)     - pfpt_pkg::DIFF_W'(rd_x);
    dz_e  = pfpt_pkg::DIFF_W'(prev_z) - pfpt_pkg::DIFF_W'(rd_z);
  end

  always_ff @(posedge clk) begin
    if (tag1.valid) begin
      prev_x <= rd_x;
      prev_z <= rd_z;
    end
    cand2 <= spans && xnear && !tag1.prime;
    dz_p2 <= dz_p;
    dx_e2 <= dx_e;
    dx_p2 <= dx_p;
    dz_e2 <= dz_e;
  end

  // stage 2: exact cross products
  always_ff @(posedge clk) begin
    cand3 <= cand2;
    dpos3 <= !dz_e2[pfpt_pkg::DIFF_W-1] && (dz_e2 != '0);
    lhs3  <= pfpt_pkg::PROD_W'(dz_p2) * pfpt_pkg::PROD_W'(dx_e2);
    rhs3  <= pfpt_pkg::PROD_W'(dx_p2) * pfpt_pkg::PROD_W'(dz_e2);
  end

  // stage 3: compare, direction flips with the sign of the edge's z span
  always_comb begin
    hit  = dpos3 ? (lhs3 < rhs3) : (rhs3 < lhs3);
    flip = cand3 && hit;
    odd  = parity ^ flip;
  end

  // parity per fence, first odd fence is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      found  <= 1'b0;
      index  <= '0;
    end else if (clear) begin
      found <= 1'b0;
      index <= '0;
    end else if (tag3.valid) begin
      if (tag3.prime) begin
        parity <= 1'b0;
      end else begin
        parity <= odd;
        if (tag3.last && odd && !found) begin
          found <= 1'b1;
          index <= tag3.fence;
        end
      end
    end
  end

  assign stat.busy  = tag1.valid || tag2.valid || tag3.valid;
  assign stat.found = found;
  assign stat.index = index;

endmodule

FILE: verif/tb_polygon_fence_point_test.sv
// Testbench for polygon_fence_point_test: directed table and random requests vs. a predictor.
`timescale 1ns / 1ps

module tb_polygon_fence_point_test;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int QUIET_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int ITEMS_PER_BLOCK = 200;
  localparam int REPORT_LIMIT    = 10;
  localparam pfpt_pkg::coord_t C_MIN = 32'sh8000_0000;
  localparam pfpt_pkg::coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam pfpt_pkg::coord_t SIDE  = 32'sh000A_0000;

  typedef struct {
    logic [1:0]                   kind;
    logic [pfpt_pkg::FENCE_W-1:0] fence;
    logic [pfpt_pkg::VERT_W-1:0]  vertex;
    pfpt_pkg::coord_t             x;
    pfpt_pkg::coord_t             z;
    logic [pfpt_pkg::COUNT_W-1:0] total;
  } request_t;

  typedef struct packed {
    logic                         found;
    logic [pfpt_pkg::FENCE_W-1:0] fence;
  } query_verdict_t;

  typedef struct {
    request_t       req;
    bit             typed;
    query_verdict_t verdict;
  } stim_row_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [pfpt_pkg::CFG_W-1:0]   cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   req_type;
  logic [pfpt_pkg::FENCE_W-1:0] fence_sel;
  logic [pfpt_pkg::VERT_W-1:0]  vertex_sel;
  pfpt_pkg::coord_t             coord_x;
  pfpt_pkg::coord_t             coord_z;
  logic [pfpt_pkg::COUNT_W-1:0] vertex_total;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         inside_res;
  logic [pfpt_pkg::FENCE_W-1:0] fence_index;

  // fence table mirror
  pfpt_pkg::coord_t vx_mem [pfpt_pkg::RAM_DEPTH];
  pfpt_pkg::coord_t vz_mem [pfpt_pkg::RAM_DEPTH];
  bit               vtx_written [pfpt_pkg::RAM_DEPTH];
  int unsigned      vtx_count [pfpt_pkg::MAX_FENCES];
  int unsigned      fences_cfg = 8;

  stim_row_t      stim_rows [$];
  query_verdict_t pending_verdicts [$];
  query_verdict_t front_verdict;
  int unsigned    tx_gap_pct;
  int unsigned    rx_stall_pct;
  int unsigned    accepted_items;
  int unsigned    mismatch_count;
  int unsigned    quiet_cycles;

  polygon_fence_point_test uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .fence_sel    (fence_sel),
    .vertex_sel   (vertex_sel),
    .coord_x      (coord_x),
    .coord_z      (coord_z),
    .vertex_total (vertex_total),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .inside_res   (inside_res),
    .fence_index  (fence_index)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // even-odd ray test of one fence, exact cross-multiplied intercept compare
  function automatic bit fence_encloses(input int unsigned f, input pfpt_pkg::coord_t px,
                                        input pfpt_pkg::coord_t pz);
    int unsigned n, base, i, j;
    pfpt_pkg::coord_t xi, zi, xj, zj;
    logic signed [pfpt_pkg::DIFF_W-1:0] dz_pt, dx_edge, dx_pt, dz_edge;
    logic signed [pfpt_pkg::PROD_W-1:0] lhs, rhs;
    bit odd, crossed;
    n = vtx_count[f];
    if (n <= pfpt_pkg::SMALL_FENCE) return 1'b0;
    base = f * pfpt_pkg::MAX_VERTICES;
    odd = 1'b0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      xi = vx_mem[base + i];
      zi = vz_mem[base + i];
      xj = vx_mem[base + j];
      zj = vz_mem[base + j];
      // edge straddles the ray height and is at least partly left of the point
      if (((zi < pz && zj >= pz) || (zj < pz && zi >= pz)) && (xi <= px || xj <= px)) begin
        dz_pt   = pz - zi;
        dx_edge = xj - xi;
        dx_pt   = px - xi;
        dz_edge = zj - zi;
        lhs = dz_pt * dx_edge;
        rhs = dx_pt * dz_edge;
        // a falling edge reverses the compare
        crossed = (dz_edge > 0) ? (lhs < rhs) : (rhs < lhs);
        if (crossed) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // apply one accepted request to the mirror; returns 1 when it yields a result
  function automatic bit absorb_request(input request_t r, output query_verdict_t v);
    int unsigned slot, lim, f;
    v = '0;
    slot = r.fence * pfpt_pkg::MAX_VERTICES + r.vertex;
    case (r.kind)
      pfpt_pkg::REQ_WRITE_VERTEX: begin
        vx_mem[slot] = r.x;
        vz_mem[slot] = r.z;
        vtx_written[slot] = 1'b1;
        return 1'b0;
      end
      pfpt_pkg::REQ_SET_COUNT: begin
        vtx_count[r.fence] = (r.total > pfpt_pkg::MAX_VERTICES) ?
                             pfpt_pkg::MAX_VERTICES : r.total;
        return 1'b0;
      end
      pfpt_pkg::REQ_QUERY: begin
        lim = (fences_cfg > pfpt_pkg::MAX_FENCES) ? pfpt_pkg::MAX_FENCES : fences_cfg;
        for (f = 0; f < lim; f++) begin
          if (fence_encloses(f, r.x, r.z)) begin
            v.found = 1'b1;
            v.fence = f[pfpt_pkg::FENCE_W-1:0];
            return 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // number of vertices written contiguously from vertex zero
  function automatic int unsigned written_prefix(input int unsigned f);
    int unsigned p;
    p = 0;
    while (p < pfpt_pkg::MAX_VERTICES && vtx_written[f * pfpt_pkg::MAX_VERTICES + p]) p++;
    return p;
  endfunction

  function automatic request_t make_request(input logic [1:0] kind, input int unsigned fence,
                                            input int unsigned vertex,
                                            input pfpt_pkg::coord_t x,
                                            input pfpt_pkg::coord_t z,
                                            input int unsigned total);
    request_t r;
    r.kind   = kind;
    r.fence  = fence[pfpt_pkg::FENCE_W-1:0];
    r.vertex = vertex[pfpt_pkg::VERT_W-1:0];
    r.x      = x;
    r.z      = z;
    r.total  = total[pfpt_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t stim_row(input request_t r, input bit typed, input bit found,
                                         input int unsigned fence);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.verdict.found = found;
    row.verdict.fence = fence[pfpt_pkg::FENCE_W-1:0];
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input logic [1:0] kind, input int unsigned fence,
                                  input int unsigned vertex, input pfpt_pkg::coord_t x,
                                  input pfpt_pkg::coord_t z, input int unsigned total,
                                  input bit typed, input bit found, input int unsigned fidx);
    stim_rows = {stim_rows, stim_row(make_request(kind, fence, vertex, x, z, total),
                                     typed, found, fidx)};
  endfunction

  // coordinate scale: tiny (exact hits likely), mid, or full range (0)
  function automatic int unsigned pick_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16;
    if (roll < 80) return 1 << 20;
    return 0;
  endfunction

  function automatic pfpt_pkg::coord_t pick_coord(input int unsigned span);
    if (span == 0) return pfpt_pkg::coord_t'($urandom);
    return pfpt_pkg::coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic pfpt_pkg::coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return pfpt_pkg::coord_t'(0);
      3: return pfpt_pkg::coord_t'(-1);
      default: return pfpt_pkg::coord_t'(1);
    endcase
  endfunction

  function automatic pfpt_pkg::coord_t pick_vertex_coord(input int unsigned span);
    if ($urandom_range(0, 99) < 6) return pick_extreme();
    return pick_coord(span);
  endfunction

  // query point: on a vertex, on an edge midpoint, near a vertex, extreme, or random
  function automatic request_t make_query();
    int unsigned mode, f, n, a, b, base, span;
    logic signed [pfpt_pkg::DIFF_W-1:0] sx, sz;
    pfpt_pkg::coord_t px, pz;
    mode = $urandom_range(0, 99);
    f = $urandom_range(0, pfpt_pkg::MAX_FENCES - 1);
    n = written_prefix(f);
    base = f * pfpt_pkg::MAX_VERTICES;
    a = (n > 0) ? $urandom_range(0, n - 1) : 0;
    b = (n > 0) ? (a + 1) % n : 0;
    span = pick_span();
    px = pick_coord(span);
    pz = pick_coord(span);
    if (mode < 20 && n > 0) begin
      px = vx_mem[base + a];
      pz = vz_mem[base + a];
    end else if (mode < 40 && n > 1) begin
      sx = vx_mem[base + a] + vx_mem[base + b];
      sz = vz_mem[base + a] + vz_mem[base + b];
      px = pfpt_pkg::coord_t'(sx >>> 1);
      pz = pfpt_pkg::coord_t'(sz >>> 1);
    end else if (mode < 60 && n > 0) begin
      px = vx_mem[base + a] + pfpt_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
      pz = vz_mem[base + a] + pfpt_pkg::coord_t'(int'($urandom_range(0, 6)) - 3);
    end else if (mode < 70) begin
      px = pick_extreme();
      pz = pick_extreme();
    end
    return make_request(pfpt_pkg::REQ_QUERY, $urandom, $urandom, px, pz, $urandom);
  endfunction

  // drive one request, wait for acceptance, record its expected result
  task automatic issue(input request_t r, input bit typed, input query_verdict_t typed_v);
    query_verdict_t v;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= r.kind;
    fence_sel    <= r.fence;
    vertex_sel   <= r.vertex;
    coord_x      <= r.x;
    coord_z      <= r.z;
    vertex_total <= r.total;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (absorb_request(r, v)) begin
      if (typed) v = typed_v;
      pending_verdicts = {pending_verdicts, v};
    end
    if (r.kind != REQ_IGNORED) accepted_items++;
  endtask

  // a well-formed fence: vertices, count, then a few queries
  task automatic build_fence();
    int unsigned f, n, span, k, roll, total;
    bit reverse;
    f = $urandom_range(0, pfpt_pkg::MAX_FENCES - 1);
    roll = $urandom_range(0, 99);
    if (roll < 5) n = $urandom_range(1, pfpt_pkg::SMALL_FENCE);
    else if (roll < 78) n = $urandom_range(3, 8);
    else if (roll < 93) n = $urandom_range(9, 20);
    else n = pfpt_pkg::MAX_VERTICES;
    span = pick_span();
    reverse = $urandom_range(0, 1);
    for (k = 0; k < n; k++)
      issue(make_request(pfpt_pkg::REQ_WRITE_VERTEX, f, reverse ? n - 1 - k : k,
                         pick_vertex_coord(span), pick_vertex_coord(span), $urandom),
            1'b0, '0);
    // sometimes the count is left stale
    if ($urandom_range(0, 99) < 85) begin
      total = n;
      if (n == pfpt_pkg::MAX_VERTICES && $urandom_range(0, 1)) total = $urandom_range(33, 63);
      issue(make_request(pfpt_pkg::REQ_SET_COUNT, f, $urandom, pick_coord(0), pick_coord(0),
                         total), 1'b0, '0);
    end
    repeat ($urandom_range(1, 4)) issue(make_query(), 1'b0, '0);
  endtask

  // ignored codes, small counts, stray vertex writes
  task automatic noise_request();
    int unsigned roll, f, top;
    roll = $urandom_range(0, 99);
    f = $urandom_range(0, pfpt_pkg::MAX_FENCES - 1);
    if (roll < 40) begin
      issue(make_request(REQ_IGNORED, $urandom, $urandom, pick_coord(0), pick_coord(0),
                         $urandom), 1'b0, '0);
    end else if (roll < 70) begin
      top = written_prefix(f);
      if (top > pfpt_pkg::SMALL_FENCE) top = pfpt_pkg::SMALL_FENCE;
      issue(make_request(pfpt_pkg::REQ_SET_COUNT, f, $urandom, pick_coord(0), pick_coord(0),
                         $urandom_range(0, top)), 1'b0, '0);
    end else begin
      issue(make_request(pfpt_pkg::REQ_WRITE_VERTEX, f, $urandom, pick_coord(0),
                         pick_coord(0), $urandom), 1'b0, '0);
    end
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fence_limit(input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[pfpt_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    fences_cfg = value[pfpt_pkg::CFG_W-1:0];
  endtask

  // result receiver backpressure
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rx_stall_pct);

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] unexpected result: inside=%0b fence=%0d",
                   $time, inside_res, fence_index);
      end else begin
        front_verdict = pending_verdicts.pop_front();
        if (inside_res !== front_verdict.found || fence_index !== front_verdict.fence) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: expected inside=%0b fence=%0d, got inside=%0b fence=%0d",
                     $time, front_verdict.found, front_verdict.fence, inside_res, fence_index);
        end
      end
    end
  end

  // cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned cfg_plan [6];
    int unsigned blk, roll, target, i;
    cfg_plan = '{15, 3, 0, 8, 1, 11};
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    req_type     <= pfpt_pkg::REQ_WRITE_VERTEX;
    fence_sel    <= '0;
    vertex_sel   <= '0;
    coord_x      <= '0;
    coord_z      <= '0;
    vertex_total <= '0;
    tx_gap_pct   = 11;
    rx_stall_pct = 47;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, a square, a small fence, a full-range triangle
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 7, 31, C_MAX, C_MIN, 63, 1, 0, 0);
    add_row(REQ_IGNORED, 7, 31, C_MAX, C_MAX, 63, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 2, 0, -SIDE, -SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 2, 1, SIDE, -SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 2, 2, SIDE, SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 2, 3, -SIDE, SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_SET_COUNT, 2, 0, 0, 0, 4, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 1, 1, 2);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, SIDE, SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, SIDE, 0, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, -SIDE, 0, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 0, SIDE, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 3 * SIDE, 0, 0, 1, 0, 0);
    add_row(pfpt_pkg::REQ_SET_COUNT, 2, 0, 0, 0, pfpt_pkg::SMALL_FENCE, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 0, 0, C_MIN, C_MIN, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 0, 1, C_MAX, C_MIN, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_WRITE_VERTEX, 0, 2, C_MIN, C_MAX, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_SET_COUNT, 0, 0, 0, 0, 3, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, C_MIN + 1, C_MIN + 1, 0, 1, 1, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, C_MAX, C_MAX, 0, 0, 0, 0);
    // oversized count saturates; cleared again before any query reads the fence
    add_row(pfpt_pkg::REQ_SET_COUNT, 7, 0, 0, 0, 63, 0, 0, 0);
    add_row(pfpt_pkg::REQ_SET_COUNT, 7, 0, 0, 0, 0, 0, 0, 0);
    add_row(pfpt_pkg::REQ_SET_COUNT, 2, 0, 0, 0, 4, 0, 0, 0);
    add_row(pfpt_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    for (i = 0; i < stim_rows.size(); i++)
      issue(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].verdict);

    // random blocks, each under its own fence limit; the idling pattern changes every two blocks
    for (blk = 0; blk < 6; blk++) begin
      if (blk < 2) begin
        tx_gap_pct = 11;
        rx_stall_pct = 47;
      end else if (blk < 4) begin
        tx_gap_pct = 47;
        rx_stall_pct = 11;
      end else begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      settle();
      write_fence_limit(cfg_plan[blk]);
      target = accepted_items + ITEMS_PER_BLOCK;
      while (accepted_items < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) build_fence();
        else if (roll < 80) issue(make_query(), 1'b0, '0);
        else noise_request();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pfpt_pkg.sv
rtl/pfpt_ram.sv
rtl/pfpt_edge_unit.sv
rtl/polygon_fence_point_test.sv
verif/tb_polygon_fence_point_test.sv
